### src/ldu_pkg.sv
package ldu_pkg;

  localparam int unsigned VAL_W      = 32;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LDU_MODE    = 1'b1;

  localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] num;
    logic signed [VAL_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] quot;
  } div_rsp_t;

endpackage

### src/ldu_div.sv
module ldu_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ldu_pkg::div_req_t  req_i,
  output ldu_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned CNT_W = $clog2(ldu_pkg::ACC_W);

  logic                          busy_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [ldu_pkg::ACC_W-1:0]     nm_q;
  logic [ldu_pkg::VAL_W-1:0]     dm_q;
  logic [ldu_pkg::VAL_W-1:0]     rem_q;
  logic                          neg_q;
  logic                          num_pos_q;
  logic                          num_neg_q;
  logic                          den_zero_q;
  logic                          done_q;
  logic signed [ldu_pkg::VAL_W-1:0] quot_q;

  logic [ldu_pkg::VAL_W:0]       sh;
  logic                          qbit;
  logic [ldu_pkg::VAL_W-1:0]     rem_d;
  logic [ldu_pkg::ACC_W-1:0]     q_new;
  logic signed [ldu_pkg::VAL_W-1:0] quot_d;

  always_comb begin
    sh    = {rem_q, nm_q[ldu_pkg::ACC_W-1]};
    qbit  = (sh >= {1'b0, dm_q});
    rem_d = qbit ? ldu_pkg::VAL_W'(sh - {1'b0, dm_q}) : sh[ldu_pkg::VAL_W-1:0];
    q_new = {nm_q[ldu_pkg::ACC_W-2:0], qbit};
    if (den_zero_q) begin
      if (num_pos_q) quot_d = ldu_pkg::Q_MAX;
      else if (num_neg_q) quot_d = ldu_pkg::Q_MIN;
      else quot_d = '0;
    end else if (!neg_q) begin
      if (q_new > ldu_pkg::ACC_W'(32'h7fff_ffff)) quot_d = ldu_pkg::Q_MAX;
      else quot_d = q_new[ldu_pkg::VAL_W-1:0];
    end else begin
      if (q_new >= ldu_pkg::ACC_W'(33'h1_0000_0000) >> 1) quot_d = ldu_pkg::Q_MIN;
      else quot_d = ldu_pkg::VAL_W'(-q_new[ldu_pkg::VAL_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ldu_pkg::ACC_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      nm_q       <= req_i.num[ldu_pkg::ACC_W-1] ? ldu_pkg::ACC_W'(-req_i.num) : req_i.num;
      dm_q       <= req_i.den[ldu_pkg::VAL_W-1] ? ldu_pkg::VAL_W'(-req_i.den) : req_i.den;
      rem_q      <= '0;
      neg_q      <= req_i.num[ldu_pkg::ACC_W-1] ^ req_i.den[ldu_pkg::VAL_W-1];
      num_pos_q  <= !req_i.num[ldu_pkg::ACC_W-1] && (req_i.num != '0);
      num_neg_q  <= req_i.num[ldu_pkg::ACC_W-1];
      den_zero_q <= (req_i.den == '0);
    end else if (busy_q) begin
      nm_q  <= q_new;
      rem_q <= rem_d;
      if (cnt_q == CNT_W'(ldu_pkg::ACC_W - 1)) quot_q <= quot_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

### src/lu_doolittle_ldu_decompose.sv
// channel | direction | handshake               | payload
// input   | in        | in_valid_i / in_ready_o | a_value_i
// output  | out       | out_valid_o/out_ready_i | row_index_o col_index_o factor_value_o
//         |           |                         | zero_pivot_o last_o
// config  | in        | cfg_we_i (no wait)      | cfg_idx_i cfg_wdata_i
// loading takes one cycle per element; the n*n-th element starts an in-place factorization
// in the single work memory, one read per cycle: each entry reads its element, then for each
// multiply-subtract reads two operands, multiplies and subtracts; an l entry then waits on
// the bit-serial divider, as does each emitted ldu quotient right of the diagonal
// reset clears counters, flags and the sequencer; memory contents are not cleared
// no input is taken while factoring or emitting; a stalled output holds the sequencer
module lu_doolittle_ldu_decompose #(
  parameter int unsigned MAX_ORDER = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [ldu_pkg::VAL_W-1:0]      a_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [ldu_pkg::IDX_W-1:0]             row_index_o,
  output logic [ldu_pkg::IDX_W-1:0]             col_index_o,
  output logic signed [ldu_pkg::VAL_W-1:0]      factor_value_o,
  output logic                                  zero_pivot_o,
  output logic                                  last_o,
  input  logic                                  cfg_we_i,
  input  logic [ldu_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [ldu_pkg::CFG_DATA_W-1:0]        cfg_wdata_i
);

  localparam int unsigned CW    = $clog2(MAX_ORDER + 1);
  localparam int unsigned DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LW    = $clog2(DEPTH + 1);
  localparam int unsigned VW    = ldu_pkg::VAL_W;
  localparam int unsigned XW    = ldu_pkg::ACC_W;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_ARD  = 4'd1;
  localparam logic [3:0] S_AWT  = 4'd2;
  localparam logic [3:0] S_LWT  = 4'd3;
  localparam logic [3:0] S_UWT  = 4'd4;
  localparam logic [3:0] S_SUB  = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_DIVW = 4'd7;
  localparam logic [3:0] E_RD   = 4'd8;
  localparam logic [3:0] E_PWT  = 4'd9;
  localparam logic [3:0] E_DWT  = 4'd10;
  localparam logic [3:0] E_DIVW = 4'd11;
  localparam logic [3:0] E_VWT  = 4'd12;

  localparam logic signed [XW-1:0] HALF = XW'(1) << (FRAC_BITS - 1);

  logic [ldu_pkg::CFG_DATA_W-1:0] size_q;
  logic                           ldu_q;
  logic [CW-1:0]                  n_eff;
  logic [LW-1:0]                  total;

  logic [3:0]                     state_q, state_d;
  logic [CW-1:0]                  i_q, i_d, j_q, j_d, k_q, k_d;
  logic                           phase_q, phase_d;
  logic [LW-1:0]                  load_q, load_d;
  logic                           flag_q, flag_d;
  logic signed [VW-1:0]           piv_q, piv_d;
  logic signed [VW-1:0]           opa_q;
  logic signed [XW-1:0]           prod_q;
  logic signed [XW-1:0]           acc_q, acc_d;

  logic signed [VW-1:0]           mem [DEPTH];
  logic signed [VW-1:0]           rd_q;
  logic [AW-1:0]                  rd_addr;
  logic                           we;
  logic [AW-1:0]                  waddr;
  logic signed [VW-1:0]           wdata;

  logic                           out_valid_q;
  logic [ldu_pkg::IDX_W-1:0]      row_q, col_q;
  logic signed [VW-1:0]           val_q;
  logic                           zp_q, last_q;
  logic                           out_load;
  logic signed [VW-1:0]           out_val;
  logic                           is_last;

  ldu_pkg::div_req_t              div_req;
  ldu_pkg::div_rsp_t              div_rsp;

  logic [CW-1:0]                  r_sel, c_sel;
  logic [LW-1:0]                  load_pos;
  logic                           in_xfer;
  logic signed [XW:0]             diff;
  logic signed [XW-1:0]           sub_res;
  logic signed [XW-1:0]           rsum;
  logic signed [XW-1:0]           rshift;
  logic signed [VW-1:0]           u_round;

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c,
                                            input logic [CW-1:0] n);
    logic [AW-1:0] a;
    a = AW'(AW'(r) * AW'(n)) + AW'(c);
    return a;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= ldu_pkg::CFG_DATA_W'(8);
      ldu_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ldu_pkg::CFG_MATRIX_SIZE: size_q <= cfg_wdata_i;
        ldu_pkg::CFG_LDU_MODE:    ldu_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (size_q == '0) n_eff = CW'(1);
    else if (size_q > ldu_pkg::CFG_DATA_W'(MAX_ORDER)) n_eff = CW'(MAX_ORDER);
    else n_eff = CW'(size_q);
    total = LW'(LW'(n_eff) * LW'(n_eff));
  end

  assign in_ready_o = (state_q == S_LOAD);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign load_pos   = (load_q >= total) ? '0 : load_q;
  assign r_sel      = phase_q ? j_q : i_q;
  assign c_sel      = phase_q ? i_q : j_q;
  assign is_last    = (i_q == n_eff - 1'b1) && (j_q == n_eff - 1'b1);

  // saturating subtract of the product and rounding of a u entry
  always_comb begin
    diff = {acc_q[XW-1], acc_q} - {prod_q[XW-1], prod_q};
    if (diff[XW] != diff[XW-1]) sub_res = diff[XW] ? ldu_pkg::ACC_MIN : ldu_pkg::ACC_MAX;
    else sub_res = diff[XW-1:0];
    rsum   = acc_q + HALF;
    rshift = rsum >>> FRAC_BITS;
    if (acc_q > ldu_pkg::ACC_MAX - HALF) u_round = ldu_pkg::Q_MAX;
    else if (rshift > XW'(ldu_pkg::Q_MAX)) u_round = ldu_pkg::Q_MAX;
    else if (rshift < XW'(ldu_pkg::Q_MIN)) u_round = ldu_pkg::Q_MIN;
    else u_round = rshift[VW-1:0];
  end

  always_comb begin
    case (state_q)
      S_ARD:   rd_addr = addr_of(r_sel, c_sel, n_eff);
      S_AWT:   rd_addr = addr_of(r_sel, '0, n_eff);
      S_SUB:   rd_addr = addr_of(r_sel, k_q + 1'b1, n_eff);
      S_LWT:   rd_addr = addr_of(k_q, c_sel, n_eff);
      E_RD:    rd_addr = (ldu_q && j_q > i_q) ? addr_of(i_q, i_q, n_eff)
                                              : addr_of(i_q, j_q, n_eff);
      E_PWT:   rd_addr = addr_of(i_q, j_q, n_eff);
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = addr_of(r_sel, c_sel, n_eff);
    wdata = u_round;
    if (state_q == S_LOAD && in_xfer) begin
      we    = 1'b1;
      waddr = AW'(load_pos);
      wdata = a_value_i;
    end else if (state_q == S_FIN && !phase_q) begin
      we = 1'b1;
    end else if (state_q == S_DIVW && div_rsp.done) begin
      we    = 1'b1;
      wdata = div_rsp.quot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    div_req.start = (state_q == S_FIN && phase_q) || (state_q == E_DWT);
    div_req.num   = (state_q == E_DWT) ? (XW'(rd_q) <<< FRAC_BITS) : acc_q;
    div_req.den   = piv_q;
  end

  ldu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    phase_d  = phase_q;
    load_d   = load_q;
    flag_d   = flag_q;
    piv_d    = piv_q;
    acc_d    = acc_q;
    out_load = 1'b0;
    out_val  = rd_q;
    case (state_q)
      S_LOAD: begin
        if (in_xfer) begin
          if (load_pos + 1'b1 == total) begin
            load_d  = '0;
            i_d     = '0;
            j_d     = '0;
            phase_d = 1'b0;
            flag_d  = 1'b0;
            state_d = S_ARD;
          end else begin
            load_d = load_pos + 1'b1;
          end
        end
      end
      S_ARD: state_d = S_AWT;
      S_AWT: begin
        acc_d   = XW'(rd_q) <<< FRAC_BITS;
        k_d     = '0;
        state_d = (i_q != '0) ? S_LWT : S_FIN;
      end
      S_LWT: state_d = S_UWT;
      S_UWT: state_d = S_SUB;
      S_SUB: begin
        acc_d   = sub_res;
        k_d     = k_q + 1'b1;
        state_d = (k_q + 1'b1 < i_q) ? S_LWT : S_FIN;
      end
      S_FIN: begin
        if (phase_q) begin
          state_d = S_DIVW;
        end else begin
          if (j_q == i_q) begin
            piv_d = u_round;
            if (u_round == '0) flag_d = 1'b1;
          end
          if (j_q == n_eff - 1'b1) begin
            if (i_q == n_eff - 1'b1) begin
              i_d     = '0;
              j_d     = '0;
              state_d = E_RD;
            end else begin
              phase_d = 1'b1;
              j_d     = i_q + 1'b1;
              state_d = S_ARD;
            end
          end else begin
            j_d     = j_q + 1'b1;
            state_d = S_ARD;
          end
        end
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          if (j_q == n_eff - 1'b1) begin
            i_d     = i_q + 1'b1;
            j_d     = i_q + 1'b1;
            phase_d = 1'b0;
          end else begin
            j_d = j_q + 1'b1;
          end
          state_d = S_ARD;
        end
      end
      E_RD: begin
        if (!out_valid_q) state_d = (ldu_q && j_q > i_q) ? E_PWT : E_VWT;
      end
      E_PWT: begin
        piv_d   = rd_q;
        state_d = E_DWT;
      end
      E_DWT: state_d = E_DIVW;
      E_DIVW: begin
        if (div_rsp.done) begin
          out_load = 1'b1;
          out_val  = div_rsp.quot;
        end
      end
      E_VWT: out_load = 1'b1;
      default: state_d = S_LOAD;
    endcase
    if (out_load) begin
      if (is_last) begin
        state_d = S_LOAD;
      end else begin
        state_d = E_RD;
        if (j_q == n_eff - 1'b1) begin
          i_d = i_q + 1'b1;
          j_d = '0;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      phase_q     <= 1'b0;
      load_q      <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      phase_q <= phase_d;
      load_q  <= load_d;
      flag_q  <= flag_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    piv_q <= piv_d;
    acc_q <= acc_d;
    if (state_q == S_LWT) opa_q <= rd_q;
    if (state_q == S_UWT) prod_q <= XW'(opa_q) * XW'(rd_q);
    if (out_load) begin
      row_q  <= ldu_pkg::IDX_W'(i_q);
      col_q  <= ldu_pkg::IDX_W'(j_q);
      val_q  <= out_val;
      zp_q   <= flag_q;
      last_q <= is_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign row_index_o    = row_q;
  assign col_index_o    = col_q;
  assign factor_value_o = val_q;
  assign zero_pivot_o   = zp_q;
  assign last_o         = last_q;

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIVW || state_q == E_DIVW))
    else $error("divider finished outside a wait state");

  a_k_below_i: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LWT) |-> (k_q < i_q))
    else $error("inner index out of range");

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && is_last) |=> (state_q == S_LOAD))
    else $error("sequencer did not return to loading after last entry");

  a_no_load_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q)
    else $error("output register overwritten while full");

endmodule
